FILE: rtl/core/rcpr_pkg.sv
// Package for the ranked code pair relation block.
// Holds field widths, configuration register indexes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package rcpr_pkg;

	localparam int CODE_W        = 32;
	localparam int RANK_W        = 4;
	localparam int ROW_W         = 6;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 4;
	localparam int DEF_MAX_RANKS = 8;
	localparam int DEF_MAX_ROWS  = 64;

	localparam logic [CODE_W-1:0] UNKNOWN_CODE = {CODE_W{1'b1}};
	localparam logic [RANK_W-1:0] RANK_NONE    = {RANK_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] CFG_RANK_COUNT    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DROP_UNRELATED = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} rcpr_state_t;

endpackage

FILE: rtl/core/ranked_code_pair_relation_top.sv
// Top level of the ranked code pair relation block.
// Depends on rcpr_pkg and rcpr_ram.
`timescale 1ns / 1ps

// A row of rank codes is taken when start is high and busy is low. Unless
// start_new_set is set, the row joins the rows already held; with the store
// full the row is dropped and no results follow. Each stored row is then
// compared with the new row, oldest first, and each kept pair leaves as one
// beat on result_valid, high for exactly one cycle; there is no back-pressure,
// so the receiver must take every beat as it comes. The final beat of a row
// carries last_of_run. The row store is one RAM holding a whole row per
// word, and its single read port feeds one compare unit, so a new row with
// index n keeps busy high while its n older rows are read in turn, while the
// last read leaves the registered RAM port and while the held-back last
// result is flushed. The first row of a set, or a row that finds the store
// full, never raises busy. Because one pair is held back until the next kept
// pair or the end of the row is known, a beat passes the registered read, the
// hold-back slot and the output register, and the last beat of a row is on
// the ports in the first cycle that busy is low again.
// Configuration writes take effect at once and must only be made while busy
// is low and no beat is still pending. The store needs no clearing after
// reset: an entry is always written before it is read.
module ranked_code_pair_relation_top #(
	parameter int MAX_RANKS = rcpr_pkg::DEF_MAX_RANKS,
	parameter int MAX_ROWS  = rcpr_pkg::DEF_MAX_ROWS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                cfg_we,
	input  logic [rcpr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rcpr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                start_new_set,
	input  logic signed [rcpr_pkg::CODE_W-1:0]  code_0,
	input  logic signed [rcpr_pkg::CODE_W-1:0]  code_1,
	input  logic signed [rcpr_pkg::CODE_W-1:0]  code_2,
	input  logic signed [rcpr_pkg::CODE_W-1:0]  code_3,
	input  logic signed [rcpr_pkg::CODE_W-1:0]  code_4,
	input  logic signed [rcpr_pkg::CODE_W-1:0]  code_5,
	input  logic signed [rcpr_pkg::CODE_W-1:0]  code_6,
	input  logic signed [rcpr_pkg::CODE_W-1:0]  code_7,
	output logic                                result_valid,
	output logic [rcpr_pkg::ROW_W-1:0]          older_row,
	output logic [rcpr_pkg::ROW_W-1:0]          newer_row,
	output logic signed [rcpr_pkg::RANK_W-1:0]  lower_rank,
	output logic signed [rcpr_pkg::RANK_W-1:0]  upper_rank,
	output logic                                last_of_run
);

	import rcpr_pkg::*;

	localparam int IDX_W  = $clog2(MAX_ROWS);
	localparam int HELD_W = $clog2(MAX_ROWS + 1);
	localparam int RNK_W  = $clog2(MAX_RANKS + 1);
	localparam int WORD_W = MAX_RANKS * CODE_W;

	// Control and configuration state.
	rcpr_state_t       state_q, state_d;
	logic [RNK_W-1:0]  ranks_q;
	logic              drop_q;
	logic [HELD_W-1:0] rows_held_q;
	logic [IDX_W-1:0]  newer_q;
	logic [IDX_W-1:0]  rd_idx_q;

	// The new row, kept in flops so every lane reaches the compare unit.
	logic [MAX_RANKS-1:0][CODE_W-1:0] new_row_q;
	logic [MAX_RANKS-1:0][CODE_W-1:0] in_row;
	logic [7:0][CODE_W-1:0]           code_all;

	// Compare stage, aligned with the registered RAM read.
	logic                             valid_s1;
	logic [IDX_W-1:0]                 idx_s1;
	logic [MAX_RANKS-1:0][CODE_W-1:0] old_row_s1;
	logic signed [RANK_W-1:0]         cmp_lo;
	logic signed [RANK_W-1:0]         cmp_hi;
	logic                             keep;

	// One kept pair is held back until we know whether it is the last.
	logic                     pend_valid_q;
	logic [IDX_W-1:0]         pend_older_q;
	logic signed [RANK_W-1:0] pend_lo_q;
	logic signed [RANK_W-1:0] pend_hi_q;

	// Output register.
	logic                     out_valid_q;
	logic [ROW_W-1:0]         out_older_q;
	logic [ROW_W-1:0]         out_newer_q;
	logic signed [RANK_W-1:0] out_lo_q;
	logic signed [RANK_W-1:0] out_hi_q;
	logic                     out_last_q;

	logic              accept;
	logic [HELD_W-1:0] held_eff;
	logic              store_full;
	logic              rd_last;
	logic              flush;

	assign code_all = {code_7, code_6, code_5, code_4, code_3, code_2, code_1, code_0};

	always_comb begin
		for (int k = 0; k < MAX_RANKS; k++) begin
			in_row[k] = code_all[k];
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign held_eff   = start_new_set ? '0 : rows_held_q;
	assign store_full = (held_eff == HELD_W'(MAX_ROWS));
	assign rd_last    = (rd_idx_q == (newer_q - IDX_W'(1)));
	assign flush      = (state_q == ST_DRAIN) && !valid_s1;

	rcpr_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_ROWS)
	) u_row_store (
		.clk   (clk),
		.we    (accept && !store_full),
		.waddr (held_eff[IDX_W-1:0]),
		.wdata (in_row),
		.raddr (rd_idx_q),
		.rdata (old_row_s1)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !store_full && (held_eff != '0)) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (rd_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!valid_s1) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration, row bookkeeping and read address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ranks_q     <= RNK_W'(MAX_RANKS);
			drop_q      <= 1'b0;
			rows_held_q <= '0;
			newer_q     <= '0;
			rd_idx_q    <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RANK_COUNT: begin
						// Counts above the lane count act as the lane count.
						ranks_q <= (int'(cfg_wdata) > MAX_RANKS) ? RNK_W'(MAX_RANKS)
						                                         : RNK_W'(cfg_wdata);
					end
					CFG_DROP_UNRELATED: begin
						drop_q <= cfg_wdata[0];
					end
					default: begin
					end
				endcase
			end
			if (accept) begin
				rows_held_q <= store_full ? held_eff : held_eff + HELD_W'(1);
				if (!store_full) begin
					newer_q <= held_eff[IDX_W-1:0];
				end
				rd_idx_q <= '0;
			end else if (state_q == ST_RUN) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
			valid_s1 <= (state_q == ST_RUN);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !store_full) begin
			new_row_q <= in_row;
		end
		idx_s1 <= rd_idx_q;
	end

	// Compare unit: scan ranks upward, skip unknowns, stop at the first mismatch.
	always_comb begin
		logic stop;
		stop   = 1'b0;
		cmp_lo = RANK_NONE;
		cmp_hi = RANK_W'(ranks_q) - RANK_W'(1);
		for (int k = 0; k < MAX_RANKS; k++) begin
			if ((RNK_W'(k) < ranks_q) && !stop) begin
				if ((old_row_s1[k] == UNKNOWN_CODE) || (new_row_q[k] == UNKNOWN_CODE)) begin
					stop = stop;
				end else if (old_row_s1[k] != new_row_q[k]) begin
					cmp_hi = RANK_W'(k) - RANK_W'(1);
					stop   = 1'b1;
				end else begin
					cmp_lo = RANK_W'(k);
				end
			end
		end
	end

	assign keep = valid_s1 && !(drop_q && (cmp_lo == RANK_NONE) && (cmp_hi == RANK_NONE));

	// Hold-back slot and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= (keep && pend_valid_q) || (flush && pend_valid_q);
			if (keep) begin
				pend_valid_q <= 1'b1;
			end else if (flush) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			pend_older_q <= idx_s1;
			pend_lo_q    <= cmp_lo;
			pend_hi_q    <= cmp_hi;
		end
		if ((keep || flush) && pend_valid_q) begin
			out_older_q <= ROW_W'(pend_older_q);
			out_newer_q <= ROW_W'(newer_q);
			out_lo_q    <= pend_lo_q;
			out_hi_q    <= pend_hi_q;
			out_last_q  <= flush;
		end
	end

	assign result_valid = out_valid_q;
	assign older_row    = out_older_q;
	assign newer_row    = out_newer_q;
	assign lower_rank   = out_lo_q;
	assign upper_rank   = out_hi_q;
	assign last_of_run  = out_last_q;

`ifndef SYNTH
	// A beat only leaves for a row whose work had been under way.
	a_beat_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result beat without a preceding busy cycle");

	// The final beat of a row coincides with the block returning to idle.
	a_last_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_of_run) |-> !busy)
		else $error("last beat while still busy");

	// Nothing may be left in the hold-back slot once the block is idle.
	a_no_pending_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("pair left pending after the row finished");

	// Reads only touch rows older than the new one.
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (rd_idx_q < newer_q))
		else $error("read address beyond the stored rows");

	// The row count never exceeds the store.
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rows_held_q <= HELD_W'(MAX_ROWS))
		else $error("row count above capacity");
`endif

endmodule

FILE: rtl/core/rcpr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rcpr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
